// ----- src/txdrt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Transmit descriptor ring tracker package
// Ring geometry, frame limits, request and status codes and the layout of one
// descriptor slot as it is kept in the slot memory.
// ----------------------------------------------------------------------------
package txdrt_pkg;

   // Ring geometry.
   localparam int RING_DEPTH = 64;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int N_W        = IDX_W + 1;

   // Field widths of the request and response ports.
   localparam int CSR_W      = 7;
   localparam int LEN_IN_W   = 16;
   localparam int LEN_W      = 11;
   localparam int WORD_W     = 16;
   localparam int PORT_W     = 6;
   localparam int SLOT_W     = 6;
   localparam int PKTS_W     = 6;
   localparam int BYTES_W    = 17;
   localparam int FREE_W     = 6;
   localparam int ACC_W      = LEN_W + N_W;

   // Frame length limits in bytes.
   localparam int MIN_FRAME  = 60;
   localparam int MAX_FRAME  = 1518;

   // Request operations.
   typedef enum logic [1:0] {
      OP_SUBMIT  = 2'd0,
      OP_HW_DONE = 2'd1,
      OP_RECLAIM = 2'd2,
      OP_RESET   = 2'd3
   } op_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // One descriptor slot: ownership, buffer held and unpadded length.
   typedef struct packed {
      logic             owned;
      logic             held;
      logic [LEN_W-1:0] len;
   } slot_entry_type;

endpackage
`default_nettype wire

// ----- src/tx_descriptor_ring_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Transmit descriptor ring tracker
// Producer and consumer bookkeeping for a transmit descriptor ring, with the
// per-slot ownership, buffer and length state kept in one slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_op and its fields) is taken at a clock edge where start is
//   high and busy is low. Every request gives exactly one response, shown on
//   the rsp_ ports for one cycle while rsp_valid is high. The receiver cannot
//   hold a response off; it must take it in that cycle.
//   The slot memory has one write and one registered read port, and every
//   request walks a small sequencer around it, so requests are handled one at
//   a time. The states each request passes before its response:
//     submit      fill the producer slot, then finish
//     hw done     read, modify, write back when the index is in range, then finish
//     reset ring  clear, then finish
//     reclaim     check and evaluate per slot walked until the producer, a full
//                 lap or a slot hardware owns (one memory read per slot visited).
//   busy drops in the response cycle, so the next request may start there.
//   csr_ring_slots is written whenever csr_write_en is high, with no wait.
//   Reset returns the ring to empty with ring_slots at 64 and needs no
//   clearing pass: one valid bit per slot marks the entries in use.
// ----------------------------------------------------------------------------
module tx_descriptor_ring_tracker
   import txdrt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // Request channel
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_op,
   input  wire logic [LEN_IN_W-1:0] req_frame_len,
   input  wire logic                req_has_buffer,
   input  wire logic [WORD_W-1:0]   req_vlan_id,
   input  wire logic [WORD_W-1:0]   req_port_mask,
   input  wire logic [WORD_W-1:0]   req_desc_flag_bits,
   input  wire logic [SLOT_W-1:0]   req_slot_index,
   // Response channel
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic                     rsp_empty_before,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic [LEN_W-1:0]         rsp_desc_len,
   output logic [WORD_W-1:0]        rsp_desc_vlan,
   output logic [PORT_W-1:0]        rsp_desc_ports,
   output logic [WORD_W-1:0]        rsp_desc_flags,
   output logic [PKTS_W-1:0]        rsp_reclaimed_pkts,
   output logic [BYTES_W-1:0]       rsp_reclaimed_bytes,
   output logic [FREE_W-1:0]        rsp_free_slots,
   // Configuration
   input  wire logic                csr_write_en,
   input  wire logic [CSR_W-1:0]    csr_ring_slots
);

   localparam int SW     = N_W + 2;
   localparam int CLAMPW = CSR_W + N_W;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_SUBMIT   = 8'b0000_0010,
      ST_DONE_RD  = 8'b0000_0100,
      ST_DONE_WR  = 8'b0000_1000,
      ST_RC_CHECK = 8'b0001_0000,
      ST_RC_EVAL  = 8'b0010_0000,
      ST_CLEAR    = 8'b0100_0000,
      ST_FINISH   = 8'b1000_0000
   } state_type;

   // Control state
   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       prod_ff, prod_in;
   logic [IDX_W-1:0]       cons_ff, cons_in;
   logic [IDX_W-1:0]       last_ff, last_in;
   logic [RING_DEPTH-1:0]  valid_ff, valid_in;
   logic [CSR_W-1:0]       ring_slots_ff, ring_slots_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Latched request fields
   op_type                 op_ff, op_in;
   logic [LEN_IN_W-1:0]    len_ff, len_in;
   logic                   has_buf_ff, has_buf_in;
   logic [WORD_W-1:0]      vlan_ff, vlan_in;
   logic [PORT_W-1:0]      ports_ff, ports_in;
   logic [WORD_W-1:0]      flags_ff, flags_in;
   logic [SLOT_W-1:0]      sidx_ff, sidx_in;

   // Reclaim walk counters
   logic [N_W-1:0]         steps_ff, steps_in;
   logic [N_W-1:0]         pkts_ff, pkts_in;
   logic [ACC_W-1:0]       bytes_ff, bytes_in;

   // Response registers
   status_type             status_ff, status_in;
   logic                   empty_before_ff, empty_before_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [LEN_W-1:0]       dlen_ff, dlen_in;
   logic [WORD_W-1:0]      dvlan_ff, dvlan_in;
   logic [PORT_W-1:0]      dports_ff, dports_in;
   logic [WORD_W-1:0]      dflags_ff, dflags_in;
   logic [PKTS_W-1:0]      rpkts_ff, rpkts_in;
   logic [BYTES_W-1:0]     rbytes_ff, rbytes_in;
   logic [FREE_W-1:0]      free_ff, free_in;

   // Slot memory
   slot_entry_type         slot_mem [RING_DEPTH];
   slot_entry_type         slot_rd_ff;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   slot_entry_type         mem_wdata;
   logic [IDX_W-1:0]       mem_raddr;

   // Helpers
   logic [CLAMPW-1:0]      slots_ext;
   logic [N_W-1:0]         n_slots;
   logic [N_W-1:0]         prod_inc, cons_inc;
   logic [IDX_W-1:0]       prod_next, cons_next;
   logic [LEN_IN_W-1:0]    padded;
   logic                   frame_bad;
   logic                   ring_full;
   logic [IDX_W+SLOT_W-1:0] sidx_ext;
   logic                   sidx_ok;
   logic [IDX_W-1:0]       sidx_idx;
   logic                   cons_owned, cons_held;
   logic signed [SW-1:0]   used_s;
   logic signed [SW-1:0]   n_s;
   logic [SW-1:0]          free_w;
   logic [N_W+FREE_W-1:0]  free_ext;
   logic [N_W+PKTS_W-1:0]  pkts_ext;
   logic [ACC_W+BYTES_W-1:0] bytes_ext;
   logic [IDX_W+SLOT_W-1:0] last_ext;

   localparam logic signed [SW-1:0] MINUS_ONE = '1;

   // Slot count in use, clamped to 2..RING_DEPTH.
   assign slots_ext = CLAMPW'(ring_slots_ff);
   always_comb begin
      if (slots_ext < CLAMPW'(2)) begin
         n_slots = N_W'(2);
      end else if (slots_ext > CLAMPW'(RING_DEPTH)) begin
         n_slots = N_W'(RING_DEPTH);
      end else begin
         n_slots = slots_ext[N_W-1:0];
      end
   end

   // Index advance with wrap at the slot count.
   assign prod_inc  = N_W'(prod_ff) + N_W'(1);
   assign cons_inc  = N_W'(cons_ff) + N_W'(1);
   assign prod_next = (prod_inc >= n_slots) ? '0 : prod_inc[IDX_W-1:0];
   assign cons_next = (cons_inc >= n_slots) ? '0 : cons_inc[IDX_W-1:0];

   // Submit checks.
   assign padded    = (len_ff < LEN_IN_W'(MIN_FRAME)) ? LEN_IN_W'(MIN_FRAME) : len_ff;
   assign frame_bad = !has_buf_ff || (len_ff == '0) || (padded > LEN_IN_W'(MAX_FRAME));
   assign ring_full = (prod_next == cons_ff);

   // Hardware-done slot index, range checked against the ring depth.
   assign sidx_ext = (IDX_W + SLOT_W)'(sidx_ff);
   assign sidx_ok  = sidx_ext < (IDX_W + SLOT_W)'(RING_DEPTH);
   assign sidx_idx = sidx_ext[IDX_W-1:0];

   // Slot at the consumer; an entry without its valid bit reads as empty.
   assign cons_owned = valid_ff[cons_ff] && slot_rd_ff.owned;
   assign cons_held  = valid_ff[cons_ff] && slot_rd_ff.held;

   // Memory read address: the returned slot for hardware done, else consumer.
   assign mem_raddr = (op_ff == OP_HW_DONE) ? sidx_idx : cons_ff;

   // Free slot count; a consumer past the slot count can make the span negative.
   assign n_s = signed'(SW'(n_slots));
   always_comb begin
      if (prod_ff >= cons_ff) begin
         used_s = signed'(SW'(prod_ff)) - signed'(SW'(cons_ff));
      end else begin
         used_s = n_s + signed'(SW'(prod_ff)) - signed'(SW'(cons_ff));
      end
   end
   always_comb begin
      if (used_s == MINUS_ONE) begin
         free_w = SW'(n_slots);
      end else if (used_s < MINUS_ONE) begin
         free_w = '0;
      end else if (used_s + signed'(SW'(1)) >= n_s) begin
         free_w = '0;
      end else begin
         free_w = unsigned'(n_s - signed'(SW'(1)) - used_s);
      end
   end

   // Saturation of the response counts to their port widths.
   assign free_ext  = (N_W + FREE_W)'(free_w[N_W-1:0]);
   assign pkts_ext  = (N_W + PKTS_W)'(pkts_ff);
   assign bytes_ext = (ACC_W + BYTES_W)'(bytes_ff);
   assign last_ext  = (IDX_W + SLOT_W)'(last_ff);

   // Sequencer and next-state logic.
   always_comb begin
      state_in      = state_ff;
      prod_in       = prod_ff;
      cons_in       = cons_ff;
      last_in       = last_ff;
      valid_in      = valid_ff;
      ring_slots_in = csr_write_en ? csr_ring_slots : ring_slots_ff;
      rsp_valid_in  = 1'b0;
      op_in         = op_ff;
      len_in        = len_ff;
      has_buf_in    = has_buf_ff;
      vlan_in       = vlan_ff;
      ports_in      = ports_ff;
      flags_in      = flags_ff;
      sidx_in       = sidx_ff;
      steps_in      = steps_ff;
      pkts_in       = pkts_ff;
      bytes_in      = bytes_ff;
      status_in     = status_ff;
      empty_before_in = empty_before_ff;
      slot_in       = slot_ff;
      dlen_in       = dlen_ff;
      dvlan_in      = dvlan_ff;
      dports_in     = dports_ff;
      dflags_in     = dflags_ff;
      rpkts_in      = rpkts_ff;
      rbytes_in     = rbytes_ff;
      free_in       = free_ff;
      mem_we        = 1'b0;
      mem_waddr     = prod_ff;
      mem_wdata     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in        = op_type'(req_op);
               len_in       = req_frame_len;
               has_buf_in   = req_has_buffer;
               vlan_in      = req_vlan_id;
               ports_in     = req_port_mask[PORT_W-1:0];
               flags_in     = req_desc_flag_bits;
               sidx_in      = req_slot_index;
               steps_in     = '0;
               pkts_in      = '0;
               bytes_in     = '0;
               status_in    = STATUS_OK;
               empty_before_in = 1'b0;
               dlen_in      = '0;
               dvlan_in     = '0;
               dports_in    = '0;
               dflags_in    = '0;
               rpkts_in     = '0;
               rbytes_in    = '0;
               case (op_type'(req_op))
                  OP_SUBMIT:  state_in = ST_SUBMIT;
                  OP_HW_DONE: state_in = ST_DONE_RD;
                  OP_RECLAIM: state_in = ST_RC_CHECK;
                  OP_RESET:   state_in = ST_CLEAR;
                  default:    state_in = ST_CLEAR;
               endcase
            end
         end

         // Fill the producer slot and hand it to hardware.
         ST_SUBMIT: begin
            if (frame_bad) begin
               status_in = STATUS_INVALID;
            end else if (ring_full) begin
               status_in = STATUS_FULL;
            end else begin
               empty_before_in   = (prod_ff == cons_ff);
               last_in           = prod_ff;
               mem_we            = 1'b1;
               mem_waddr         = prod_ff;
               mem_wdata.owned   = 1'b1;
               mem_wdata.held    = 1'b1;
               mem_wdata.len     = len_ff[LEN_W-1:0];
               valid_in[prod_ff] = 1'b1;
               prod_in           = prod_next;
               dlen_in           = padded[LEN_W-1:0];
               dvlan_in          = vlan_ff;
               dports_in         = ports_ff;
               dflags_in         = flags_ff;
            end
            state_in = ST_FINISH;
         end

         // The returned slot is being read.
         ST_DONE_RD: begin
            state_in = sidx_ok ? ST_DONE_WR : ST_FINISH;
         end

         // Write a valid slot back with its ownership bit cleared.
         ST_DONE_WR: begin
            if (valid_ff[sidx_idx]) begin
               mem_we          = 1'b1;
               mem_waddr       = sidx_idx;
               mem_wdata       = slot_rd_ff;
               mem_wdata.owned = 1'b0;
            end
            state_in = ST_FINISH;
         end

         // Stop at the producer or after a full lap, else read the consumer slot.
         ST_RC_CHECK: begin
            if ((cons_ff == prod_ff) || (steps_ff == N_W'(RING_DEPTH))) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_RC_EVAL;
            end
         end

         // Free the consumer slot unless hardware still owns it.
         ST_RC_EVAL: begin
            if (cons_owned) begin
               state_in = ST_FINISH;
            end else begin
               if (cons_held) begin
                  pkts_in           = pkts_ff + N_W'(1);
                  bytes_in          = bytes_ff + ACC_W'(slot_rd_ff.len);
                  valid_in[cons_ff] = 1'b0;
               end
               cons_in  = cons_next;
               steps_in = steps_ff + N_W'(1);
               state_in = ST_RC_CHECK;
            end
         end

         // Empty the ring: dropping every valid bit clears ownership and buffers.
         ST_CLEAR: begin
            valid_in = '0;
            prod_in  = '0;
            cons_in  = '0;
            last_in  = '0;
            state_in = ST_FINISH;
         end

         // Load the remaining response fields and raise the strobe.
         ST_FINISH: begin
            slot_in  = last_ext[SLOT_W-1:0];
            free_in  = (free_ext > (N_W + FREE_W)'(2 ** FREE_W - 1)) ?
                       '1 : free_ext[FREE_W-1:0];
            rpkts_in = (pkts_ext > (N_W + PKTS_W)'(2 ** PKTS_W - 1)) ?
                       '1 : pkts_ext[PKTS_W-1:0];
            rbytes_in = (bytes_ext > (ACC_W + BYTES_W)'(2 ** BYTES_W - 1)) ?
                        '1 : bytes_ext[BYTES_W-1:0];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         prod_ff       <= '0;
         cons_ff       <= '0;
         last_ff       <= '0;
         valid_ff      <= '0;
         ring_slots_ff <= CSR_W'(64);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prod_ff       <= prod_in;
         cons_ff       <= cons_in;
         last_ff       <= last_in;
         valid_ff      <= valid_in;
         ring_slots_ff <= ring_slots_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      len_ff       <= len_in;
      has_buf_ff   <= has_buf_in;
      vlan_ff      <= vlan_in;
      ports_ff     <= ports_in;
      flags_ff     <= flags_in;
      sidx_ff      <= sidx_in;
      steps_ff     <= steps_in;
      pkts_ff      <= pkts_in;
      bytes_ff     <= bytes_in;
      status_ff    <= status_in;
      empty_before_ff <= empty_before_in;
      slot_ff      <= slot_in;
      dlen_ff      <= dlen_in;
      dvlan_ff     <= dvlan_in;
      dports_ff    <= dports_in;
      dflags_ff    <= dflags_in;
      rpkts_ff     <= rpkts_in;
      rbytes_ff    <= rbytes_in;
      free_ff      <= free_in;
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      slot_rd_ff <= slot_mem[mem_raddr];
   end

   // Outputs.
   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_empty_before    = empty_before_ff;
   assign rsp_slot            = slot_ff;
   assign rsp_desc_len        = dlen_ff;
   assign rsp_desc_vlan       = dvlan_ff;
   assign rsp_desc_ports      = dports_ff;
   assign rsp_desc_flags      = dflags_ff;
   assign rsp_reclaimed_pkts  = rpkts_ff;
   assign rsp_reclaimed_bytes = rbytes_ff;
   assign rsp_free_slots      = free_ff;

endmodule
`default_nettype wire

// ----- src/txdrt_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Transmit descriptor ring tracker port checker
// Watches the top-level ports for request sequencing and response consistency.
// ----------------------------------------------------------------------------
module txdrt_checker
   import txdrt_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                rsp_valid,
   input wire logic [1:0]          rsp_status,
   input wire logic [LEN_W-1:0]    rsp_desc_len,
   input wire logic [PKTS_W-1:0]   rsp_reclaimed_pkts,
   input wire logic [BYTES_W-1:0]  rsp_reclaimed_bytes
);

   // An accepted request keeps the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after accepting a request");

   // A response strobe lasts one cycle.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // A rejected submit carries no descriptor and no reclaim counts.
   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STATUS_OK) |->
         (rsp_desc_len == '0) && (rsp_reclaimed_pkts == '0) &&
         (rsp_reclaimed_bytes == '0))
      else $error("rejected request carries descriptor or reclaim data");

   // A written descriptor length lies within the frame limits.
   a_desc_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_desc_len != '0) |->
         (rsp_desc_len >= LEN_W'(MIN_FRAME)) && (rsp_desc_len <= LEN_W'(MAX_FRAME)))
      else $error("descriptor length outside frame limits");

   // Bytes are freed only together with packets.
   a_bytes_need_pkts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_reclaimed_pkts == '0) |-> (rsp_reclaimed_bytes == '0))
      else $error("reclaimed bytes without reclaimed packets");

endmodule

bind tx_descriptor_ring_tracker txdrt_checker u_txdrt_checker (.*);
`default_nettype wire
